>>> hdl/ires_pkg.sv
`default_nettype none

package ires_pkg;

  // Fixed field widths
  localparam int unsigned POS_W  = 16;
  localparam int unsigned BND_W  = 17;
  localparam int unsigned LVL_W  = 16;
  localparam int unsigned CFG_W  = 17;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned QUO_W  = 16;
  localparam int unsigned FRAC_W = 15;

  localparam logic [LVL_W-1:0] UNITY_GAIN = 16'h8000;

  typedef enum logic [1:0] {
    MODE_RESTART = 2'd0,
    MODE_APPEND  = 2'd1,
    MODE_READ    = 2'd2,
    MODE_NOP     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_PAST_END = 2'd1,
    STAT_FULL     = 2'd2
  } status_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_REVERSE     = 3'd0,
    CFG_ATTACK_END  = 3'd1,
    CFG_DECAY_END   = 3'd2,
    CFG_SUSTAIN_END = 3'd3,
    CFG_HOLD_END    = 3'd4,
    CFG_ATTACK_LVL  = 3'd5,
    CFG_DECAY_LVL   = 3'd6,
    CFG_SUSTAIN_LVL = 3'd7
  } cfg_idx_e;

  // Divider status towards the sequencer
  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_sts_t;

  // Saturate a level register to unity
  function automatic logic [LVL_W-1:0] sat_level(input logic [LVL_W-1:0] lvl);
    sat_level = (lvl > UNITY_GAIN) ? UNITY_GAIN : lvl;
  endfunction

endpackage

`default_nettype wire

>>> hdl/ires_ram.sv
`default_nettype none

module ires_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/ires_div.sv
`default_nettype none

// Restoring divider, one quotient bit a cycle. The quotient must fit QUO_W bits,
// i.e. the upper half of the dividend is below the divisor.
module ires_div
  import ires_pkg::*;
#(
  parameter int unsigned DEN_W = 17
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [2*QUO_W-1:0] num_i,
  input  wire logic [DEN_W-1:0]   den_i,
  output div_sts_t                sts_o
);

  localparam int unsigned CNT_W = $clog2(QUO_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] lo_q;
  logic [QUO_W-1:0] quot_q;

  logic [DEN_W:0]   trial;
  logic             fits;
  logic [DEN_W:0]   diff;

  assign trial = {rem_q, lo_q[QUO_W-1]};
  assign fits  = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {{(DEN_W-QUO_W){1'b0}}, num_i[2*QUO_W-1:QUO_W]};
      lo_q  <= num_i[QUO_W-1:0];
    end else if (busy_q) begin
      rem_q  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      lo_q   <= {lo_q[QUO_W-2:0], 1'b0};
      quot_q <= {quot_q[QUO_W-2:0], fits};
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.quot = quot_q;

endmodule

`default_nettype wire

>>> hdl/impulse_reverse_envelope_shaper.sv
`default_nettype none

// Channel    Direction  Handshake                 Word
// input      in         in_valid_i / in_stall_o   mode_i, in_sample_i, read_position_i
// output     out        out_valid_o / out_stall_i out_sample_o, status_o
// config     in         cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// A shaped read holds the block through the bound, segment, multiply, divider start, divide,
// gain, scale, round and done states; restart, append, no-op and rejected reads go to done.
// The 16-step restoring divider computes the ramp fraction.
// The sample store has no reset: only entries appended since the last restart are read.
// Reset clears the stored length, the sequencer and the configuration and output registers to their defaults.
// No new word is taken while a finished result waits in the done state under out_stall_i.
module impulse_reverse_envelope_shaper
  import ires_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = 65536,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [1:0]             mode_i,
  input  wire logic [SAMPLE_BITS-1:0] in_sample_i,
  input  wire logic [POS_W-1:0]       read_position_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic      [SAMPLE_BITS-1:0] out_sample_o,
  output logic      [1:0]             status_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [IDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i
);

  localparam int unsigned ADDR_W = $clog2(MAX_SAMPLES);
  localparam int unsigned LEN_W  = $clog2(MAX_SAMPLES + 1);
  // Common width for positions, bounds and lengths
  localparam int unsigned CW     = (LEN_W > BND_W) ? LEN_W : BND_W;
  localparam int unsigned PROD_W = SAMPLE_BITS + LVL_W + 1;
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_SAMPLES);
  localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << FRAC_W) - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_BOUND,
    S_SEG,
    S_MUL,
    S_DIVGO,
    S_DIV,
    S_GAIN,
    S_SCALE,
    S_ROUND,
    S_DONE
  } state_e;

  // Configuration registers
  logic             reverse_q;
  logic [BND_W-1:0] attack_end_q;
  logic [BND_W-1:0] decay_end_q;
  logic [BND_W-1:0] sustain_end_q;
  logic [BND_W-1:0] hold_end_q;
  logic [LVL_W-1:0] attack_lvl_q;
  logic [LVL_W-1:0] decay_lvl_q;
  logic [LVL_W-1:0] sustain_lvl_q;

  logic [LEN_W-1:0] len_q;

  state_e           state_q;
  logic             out_valid_q;
  logic [SAMPLE_BITS-1:0] out_sample_q;
  logic [1:0]       out_status_q;

  // Datapath registers
  logic [POS_W-1:0] pos_q;
  logic [CW-1:0]    bnd_q [4];
  logic [CW-1:0]    den_q;
  logic [POS_W-1:0] off_q;
  logic [LVL_W-1:0] lvl_start_q;
  logic [LVL_W-1:0] dmag_q;
  logic             neg_q;
  logic [2*QUO_W-1:0] prod_q;
  logic [LVL_W-1:0] gain_q;
  logic signed [PROD_W-1:0] scaled_q;
  logic [SAMPLE_BITS-1:0] res_sample_q;
  status_e          res_status_q;

  // Accept side
  logic             accept;
  logic             out_free;
  mode_e            mode_in;
  logic [CW-1:0]    pos_in;
  logic [CW-1:0]    len_ext;
  logic             store_full;
  logic             past_end;
  logic [CW-1:0]    rev_idx;
  logic [CW-1:0]    rd_idx;
  logic             ram_we;
  logic             ram_re;
  status_e          acc_status;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  // Envelope side
  logic [BND_W-1:0] run_max [4];
  logic [CW-1:0]    bnd_min [4];
  logic [CW-1:0]    pos_ext;
  logic [CW-1:0]    seg_s;
  logic [CW-1:0]    seg_e;
  logic [LVL_W-1:0] seg_ls;
  logic [LVL_W-1:0] seg_le;
  logic [CW-1:0]    seg_off;
  logic [LVL_W-1:0] lvl_atk;
  logic [LVL_W-1:0] lvl_dcy;
  logic [LVL_W-1:0] lvl_sus;

  logic             div_start;
  div_sts_t         div_sts;

  logic signed [PROD_W-1:0] samp_ext;
  logic signed [PROD_W-1:0] gain_ext;
  logic signed [PROD_W-1:0] biased;
  logic signed [PROD_W-1:0] shifted;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign mode_in    = mode_e'(mode_i);
  assign pos_in     = CW'(read_position_i);
  assign len_ext    = CW'(len_q);
  assign store_full = (len_q == LEN_FULL);
  assign past_end   = (pos_in >= len_ext);
  assign rev_idx    = len_ext - pos_in - 1'b1;
  assign rd_idx     = reverse_q ? rev_idx : pos_in;

  assign ram_we = accept && (mode_in == MODE_APPEND) && !store_full;
  assign ram_re = accept && (mode_in == MODE_READ) && !past_end;

  always_comb begin
    unique case (mode_in)
      MODE_RESTART: acc_status = STAT_OK;
      MODE_APPEND:  acc_status = store_full ? STAT_FULL : STAT_OK;
      MODE_READ:    acc_status = past_end ? STAT_PAST_END : STAT_OK;
      MODE_NOP:     acc_status = STAT_OK;
      default:      acc_status = STAT_OK;
    endcase
  end

  ires_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (len_q[ADDR_W-1:0]),
    .wdata_i (in_sample_i),
    .re_i    (ram_re),
    .raddr_i (rd_idx[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Configuration writes and stored length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_q     <= 1'b0;
      attack_end_q  <= '0;
      decay_end_q   <= '0;
      sustain_end_q <= '0;
      hold_end_q    <= '0;
      attack_lvl_q  <= UNITY_GAIN;
      decay_lvl_q   <= UNITY_GAIN;
      sustain_lvl_q <= UNITY_GAIN;
      len_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_REVERSE:     reverse_q     <= cfg_wdata_i[0];
          CFG_ATTACK_END:  attack_end_q  <= cfg_wdata_i;
          CFG_DECAY_END:   decay_end_q   <= cfg_wdata_i;
          CFG_SUSTAIN_END: sustain_end_q <= cfg_wdata_i;
          CFG_HOLD_END:    hold_end_q    <= cfg_wdata_i;
          CFG_ATTACK_LVL:  attack_lvl_q  <= cfg_wdata_i[LVL_W-1:0];
          CFG_DECAY_LVL:   decay_lvl_q   <= cfg_wdata_i[LVL_W-1:0];
          CFG_SUSTAIN_LVL: sustain_lvl_q <= cfg_wdata_i[LVL_W-1:0];
          default: ;
        endcase
      end
      if (accept && (mode_in == MODE_RESTART)) begin
        len_q <= '0;
      end else if (ram_we) begin
        len_q <= len_q + 1'b1;
      end
    end
  end

  // Clamped bounds: running maximum of the end registers, capped at the length
  assign run_max[0] = attack_end_q;
  assign run_max[1] = (decay_end_q > run_max[0]) ? decay_end_q : run_max[0];
  assign run_max[2] = (sustain_end_q > run_max[1]) ? sustain_end_q : run_max[1];
  assign run_max[3] = (hold_end_q > run_max[2]) ? hold_end_q : run_max[2];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      bnd_min[k] = (CW'(run_max[k]) < len_ext) ? CW'(run_max[k]) : len_ext;
    end
  end

  // Segment pick: the first bound above the position; empty segments fall through
  assign pos_ext = CW'(pos_q);
  assign lvl_atk = sat_level(attack_lvl_q);
  assign lvl_dcy = sat_level(decay_lvl_q);
  assign lvl_sus = sat_level(sustain_lvl_q);

  always_comb begin
    if (pos_ext < bnd_q[0]) begin
      seg_s  = '0;
      seg_e  = bnd_q[0];
      seg_ls = '0;
      seg_le = lvl_atk;
    end else if (pos_ext < bnd_q[1]) begin
      seg_s  = bnd_q[0];
      seg_e  = bnd_q[1];
      seg_ls = lvl_atk;
      seg_le = lvl_dcy;
    end else if (pos_ext < bnd_q[2]) begin
      seg_s  = bnd_q[1];
      seg_e  = bnd_q[2];
      seg_ls = lvl_dcy;
      seg_le = lvl_sus;
    end else if (pos_ext < bnd_q[3]) begin
      seg_s  = bnd_q[2];
      seg_e  = bnd_q[3];
      seg_ls = lvl_sus;
      seg_le = lvl_sus;
    end else begin
      seg_s  = bnd_q[3];
      seg_e  = len_ext;
      seg_ls = lvl_sus;
      seg_le = '0;
    end
  end

  assign seg_off = pos_ext - seg_s;

  assign div_start = (state_q == S_DIVGO);

  ires_div #(
    .DEN_W (CW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (prod_q),
    .den_i   (den_q),
    .sts_o   (div_sts)
  );

  // Scale and truncate toward zero
  assign samp_ext = PROD_W'($signed(ram_rdata));
  assign gain_ext = PROD_W'($signed({1'b0, gain_q}));
  assign biased   = scaled_q + (scaled_q[PROD_W-1] ? TRUNC_BIAS : '0);
  assign shifted  = biased >>> FRAC_W;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q        <= read_position_i;
      res_status_q <= acc_status;
      res_sample_q <= '0;
    end
    case (state_q)
      S_BOUND: begin
        for (int k = 0; k < 4; k++) begin
          bnd_q[k] <= bnd_min[k];
        end
      end
      S_SEG: begin
        den_q       <= seg_e - seg_s;
        off_q       <= seg_off[POS_W-1:0];
        lvl_start_q <= seg_ls;
        neg_q       <= (seg_le < seg_ls);
        dmag_q      <= (seg_le < seg_ls) ? (seg_ls - seg_le) : (seg_le - seg_ls);
      end
      S_MUL:   prod_q   <= (2*QUO_W)'(dmag_q) * (2*QUO_W)'(off_q);
      S_GAIN:  gain_q   <= neg_q ? (lvl_start_q - div_sts.quot) : (lvl_start_q + div_sts.quot);
      S_SCALE: scaled_q <= samp_ext * gain_ext;
      S_ROUND: res_sample_q <= shifted[SAMPLE_BITS-1:0];
      default: ;
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
      out_status_q <= STAT_OK;
    end else begin
      // load a finished word, or drop the current one once it is taken
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= ram_re ? S_BOUND : S_DONE;
          end
        end
        S_BOUND: state_q <= S_SEG;
        S_SEG:   state_q <= S_MUL;
        S_MUL:   state_q <= S_DIVGO;
        S_DIVGO: state_q <= S_DIV;
        S_DIV: begin
          if (div_sts.done) begin
            state_q <= S_GAIN;
          end
        end
        S_GAIN:  state_q <= S_SCALE;
        S_SCALE: state_q <= S_ROUND;
        S_ROUND: state_q <= S_DONE;
        S_DONE: begin
          // hold the result until the output register frees up
          if (out_free) begin
            out_sample_q <= res_sample_q;
            out_status_q <= res_status_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign status_o     = out_status_q;

endmodule

`default_nettype wire
